// ===== rtl/core/u8tw_pkg.sv =====
// Shared types and constants for the UTF-8 text width decoder.
`timescale 1ns / 1ps

package u8tw_pkg;

	// Width of the running x position before the cap at 16 bits.
	localparam int POSITION_BITS = 16;

	// Largest running width: 2^POSITION_BITS - 1, capped at 65535.
	localparam int WIDTH_MAX = (POSITION_BITS >= 16) ? 65535 : ((1 << POSITION_BITS) - 1);

	// Field widths of one result item.
	localparam int CP_W    = 21;
	localparam int ADV_W   = 11;
	localparam int POS_W   = 16;
	localparam int COUNT_W = 16;

	// Lead-byte classes.
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	// Configuration register indexes.
	localparam logic REG_TEXT_SCALE = 1'b0;
	localparam logic REG_GLYPH_SIZE = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [7:0] TEXT_SCALE_RESET = 8'd1;
	localparam logic [6:0] GLYPH_SIZE_RESET = 7'd16;

	// One result item.
	typedef struct packed {
		logic [CP_W-1:0]    codepoint;
		logic               wide;
		logic [ADV_W-1:0]   advance;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] char_count;
		logic               is_end;
		logic               stopped;
	} result_t;

endpackage

// ===== rtl/core/u8tw_in_stage.sv =====
// Input register stage: captures one byte item and holds it until the decoder takes it.
`timescale 1ns / 1ps

module u8tw_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] text_byte,
	input  logic       take,
	output logic       in_stall,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import u8tw_pkg::*;

	logic accept;

	// The stage is free when empty or when its item moves on this cycle.
	assign in_stall = valid_s1 & ~take;
	assign accept   = in_valid & ~in_stall;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Byte payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
		end
	end

endmodule

// ===== rtl/core/u8tw_core.sv =====
// Decoder state and per-byte decode, advance and running width logic.
`timescale 1ns / 1ps

module u8tw_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          byte_s1,
	input  logic [7:0]          text_scale,
	input  logic [6:0]          glyph_size,
	output logic                res_valid,
	output u8tw_pkg::result_t   res
);
	import u8tw_pkg::*;

	logic [1:0]         pend_q, pend_n;
	logic [CP_W-1:0]    acc_q, acc_n, acc_shift, emit_cp;
	logic               halt_q, halt_n;
	logic [POS_W-1:0]   width_q, width_n;
	logic [COUNT_W-1:0] count_q, count_n, count_inc;
	logic               emit, wide;
	logic [ADV_W-1:0]   adv;
	logic [POS_W:0]     width_sum;

	// Continuation bytes contribute their low six bits.
	assign acc_shift = {acc_q[CP_W-7:0], byte_s1[5:0]};

	// Codepoint attributes of an emitted character.
	assign wide      = |emit_cp[CP_W-1:7];
	assign adv       = wide ? ((text_scale == 8'd2) ? {3'd0, glyph_size, 1'b0}
	                                                : {4'd0, glyph_size})
	                        : ({1'b0, text_scale, 2'b00} + {2'b00, text_scale, 1'b0});
	assign count_inc = (count_q == {COUNT_W{1'b1}}) ? count_q : count_q + 1'b1;
	assign width_sum = {1'b0, width_q} + {{(POS_W+1-ADV_W){1'b0}}, adv};

	// Next state and result for the byte in the input stage.
	always_comb begin
		pend_n    = pend_q;
		acc_n     = acc_q;
		halt_n    = halt_q;
		width_n   = width_q;
		count_n   = count_q;
		emit      = 1'b0;
		emit_cp   = {{(CP_W-8){1'b0}}, byte_s1};
		res_valid = 1'b0;
		res       = '0;

		if (byte_s1 == 8'd0) begin
			// End of string: report totals and start over.
			res_valid      = 1'b1;
			res.position   = width_q;
			res.char_count = count_q;
			res.is_end     = 1'b1;
			res.stopped    = halt_q | (pend_q != 2'd0);
			pend_n         = 2'd0;
			acc_n          = '0;
			halt_n         = 1'b0;
			width_n        = '0;
			count_n        = '0;
		end else if (halt_q) begin
			// Bytes after a stop are dropped.
			emit = 1'b0;
		end else if (pend_q != 2'd0) begin
			// Continuation byte.
			acc_n  = acc_shift;
			pend_n = pend_q - 2'd1;
			if (pend_q == 2'd1) begin
				acc_n = '0;
				if (acc_shift == '0) begin
					halt_n = 1'b1;
				end else begin
					emit    = 1'b1;
					emit_cp = acc_shift;
				end
			end
		end else if (!byte_s1[7]) begin
			// Plain ASCII.
			emit = 1'b1;
		end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
			acc_n  = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
			pend_n = 2'd1;
		end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
			acc_n  = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
			pend_n = 2'd2;
		end else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE) begin
			acc_n  = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
			pend_n = 2'd3;
		end else begin
			// Stray continuation byte or an illegal lead byte.
			halt_n = 1'b1;
		end

		if (emit) begin
			res_valid      = 1'b1;
			res.codepoint  = emit_cp;
			res.wide       = wide;
			res.advance    = adv;
			res.position   = width_q;
			res.char_count = count_inc;
			count_n        = count_inc;
			width_n        = (width_sum > (POS_W+1)'(WIDTH_MAX)) ? POS_W'(WIDTH_MAX)
			                                                     : width_sum[POS_W-1:0];
		end
	end

	// Decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			acc_q   <= '0;
			halt_q  <= 1'b0;
			width_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			pend_q  <= pend_n;
			acc_q   <= acc_n;
			halt_q  <= halt_n;
			width_q <= width_n;
			count_q <= count_n;
		end
	end

endmodule

// ===== rtl/core/u8tw_out_stage.sv =====
// Result register: holds one result item until the receiver takes it.
`timescale 1ns / 1ps

module u8tw_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              res_valid,
	input  u8tw_pkg::result_t res,
	input  logic              out_stall,
	output logic              take,
	output logic              out_valid,
	output u8tw_pkg::result_t out_res
);
	import u8tw_pkg::*;

	// The register can load when empty or when its item leaves this cycle.
	assign take = ~out_valid | ~out_stall;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= fire & res_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take && fire && res_valid) begin
			out_res <= res;
		end
	end

endmodule

// ===== rtl/core/utf8_decode_text_width.sv =====
// Top level of the UTF-8 text width decoder.
// Usage:
//   Input channel: one string byte per item on text_byte with in_valid/in_stall.
//   A zero byte ends the string. Each byte gives at most one result item.
//   Output channel: codepoint, wide, advance, position, char_count, is_end and
//   stopped with out_valid/out_stall. Every decoded character gives one item;
//   the zero byte gives a final item with is_end set and the total width.
//   Lead bytes, pending continuation bytes and bytes after a stop give none.
//   Configuration: write text_scale (index 0) or glyph_size (index 1) through
//   cfg_wr_en/cfg_index/cfg_wdata while no item is in flight.
// Timing:
//   One byte is accepted every cycle while in_stall is low. A byte waits in the
//   input register and is decoded into the result register when that register
//   can load. The running width and count feed back within the decode stage.
// Reset: arst_n clears both stages and the decoder state and sets text_scale
//   to 1 and glyph_size to 16.
// Stall: while out_stall holds a waiting result, the input register still
//   takes one more byte if it is empty, then in_stall rises until the result is taken.
`timescale 1ns / 1ps

module utf8_decode_text_width (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] codepoint,
	output logic        wide,
	output logic [10:0] advance,
	output logic [15:0] position,
	output logic [15:0] char_count,
	output logic        is_end,
	output logic        stopped
);
	import u8tw_pkg::*;

	logic       text_scale_q_valid_unused;
	logic [7:0] text_scale_q;
	logic [6:0] glyph_size_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	logic       fire;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	assign text_scale_q_valid_unused = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_scale_q <= TEXT_SCALE_RESET;
			glyph_size_q <= GLYPH_SIZE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TEXT_SCALE: text_scale_q <= cfg_wdata;
				REG_GLYPH_SIZE: glyph_size_q <= cfg_wdata[6:0];
				default:        text_scale_q <= text_scale_q;
			endcase
		end
	end

	// The byte in the input register is decoded when the result register can load.
	assign fire = valid_s1 & take & ~text_scale_q_valid_unused;

	u8tw_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.text_byte (text_byte),
		.take      (take),
		.in_stall  (in_stall),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	u8tw_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.byte_s1    (byte_s1),
		.text_scale (text_scale_q),
		.glyph_size (glyph_size_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	u8tw_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.take      (take),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	// Result fields.
	assign codepoint  = out_res.codepoint;
	assign wide       = out_res.wide;
	assign advance    = out_res.advance;
	assign position   = out_res.position;
	assign char_count = out_res.char_count;
	assign is_end     = out_res.is_end;
	assign stopped    = out_res.stopped;

endmodule

// ===== rtl/core/u8tw_checker.sv =====
// Port-level assertions for the UTF-8 text width decoder and their binding.
`timescale 1ns / 1ps

module u8tw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  text_byte,
	input logic        cfg_wr_en,
	input logic        cfg_index,
	input logic [7:0]  cfg_wdata,
	input logic        out_valid,
	input logic        out_stall,
	input logic [20:0] codepoint,
	input logic        wide,
	input logic [10:0] advance,
	input logic [15:0] position,
	input logic [15:0] char_count,
	input logic        is_end,
	input logic        stopped
);
	import u8tw_pkg::*;

	// A stalled result item stays and keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(codepoint) && $stable(position)
			&& $stable(char_count) && $stable(is_end))
		else $error("stalled result item changed");

	// The end item carries no character.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> codepoint == 21'd0 && !wide && advance == 11'd0)
		else $error("end item carries a character");

	// A character item is wide exactly when its codepoint is outside ASCII, and is not flagged stopped.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> wide == (codepoint >= 21'h80) && !stopped)
		else $error("character item has wrong wide or stopped flag");

	// A character item counts itself and never decodes to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> char_count != 16'd0 && codepoint != 21'd0)
		else $error("character item with zero count or zero codepoint");

endmodule

bind utf8_decode_text_width u8tw_checker u_u8tw_checker (.*);

// ===== verif/utf8_decode_text_width_chk.sv =====
// Result checker for the UTF-8 text width decoder: predicts each result item and compares it.
`timescale 1ns / 1ps

module utf8_decode_text_width_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [20:0] codepoint,
	input  logic        wide,
	input  logic [10:0] advance,
	input  logic [15:0] position,
	input  logic [15:0] char_count,
	input  logic        is_end,
	input  logic        stopped,
	output int          fail_count,
	output int          pending
);
	import u8tw_pkg::*;

	// Shadow copy of the configuration registers.
	logic [7:0]  scale;
	logic [6:0]  gsize;

	// Shadow copy of the per-string decoder state.
	logic [1:0]  cont_left;
	logic [20:0] partial_cp;
	logic        halted;
	logic [15:0] line_width;
	logic [15:0] line_count;

	int          errors;
	result_t     glyph_q[$];

	// Return to the start-of-string state; registers are kept.
	task automatic clear_line();
		cont_left  = 2'd0;
		partial_cp = 21'd0;
		halted     = 1'b0;
		line_width = 16'd0;
		line_count = 16'd0;
	endtask

	// Queue the result item of one decoded character and advance the line.
	task automatic add_glyph(input logic [20:0] cp);
		result_t r;
		int      adv;
		int      sum;
		if (cp >= 21'h80)
			adv = gsize * ((scale == 8'd2) ? 2 : 1);
		else
			adv = 6 * scale;
		if (line_count != 16'hFFFF)
			line_count = line_count + 16'd1;
		r.codepoint  = cp;
		r.wide       = (cp >= 21'h80);
		r.advance    = adv[10:0];
		r.position   = line_width;
		r.char_count = line_count;
		r.is_end     = 1'b0;
		r.stopped    = 1'b0;
		glyph_q.push_back(r);
		sum = line_width + adv;
		line_width = (sum > WIDTH_MAX) ? 16'(WIDTH_MAX) : 16'(sum);
	endtask

	// Feed one accepted byte through the shadow decoder.
	task automatic decode_byte(input logic [7:0] b);
		result_t r;
		if (b == 8'h00) begin
			r            = '0;
			r.position   = line_width;
			r.char_count = line_count;
			r.is_end     = 1'b1;
			r.stopped    = halted || (cont_left != 2'd0);
			glyph_q.push_back(r);
			clear_line();
		end else if (!halted) begin
			if (cont_left != 2'd0) begin
				// Continuation bytes only contribute their low six bits.
				partial_cp = {partial_cp[14:0], b[5:0]};
				cont_left  = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					if (partial_cp == 21'd0) begin
						halted = 1'b1;
					end else begin
						add_glyph(partial_cp);
						partial_cp = 21'd0;
					end
				end
			end else if (b < 8'h80) begin
				add_glyph({13'd0, b});
			end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				partial_cp = {16'd0, b[4:0]};
				cont_left  = 2'd1;
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				partial_cp = {17'd0, b[3:0]};
				cont_left  = 2'd2;
			end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
				partial_cp = {18'd0, b[2:0]};
				cont_left  = 2'd3;
			end else begin
				halted = 1'b1;
			end
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Compare one accepted result item with the oldest prediction.
	task automatic check_glyph();
		result_t want;
		if (glyph_q.size() == 0) begin
			$error("unexpected result item: codepoint %0h, is_end %0b", codepoint, is_end);
			errors++;
		end else begin
			want = glyph_q.pop_front();
			cmp_field("codepoint", 32'(want.codepoint), 32'(codepoint));
			cmp_field("wide", 32'(want.wide), 32'(wide));
			cmp_field("advance", 32'(want.advance), 32'(advance));
			cmp_field("position", 32'(want.position), 32'(position));
			cmp_field("char_count", 32'(want.char_count), 32'(char_count));
			cmp_field("is_end", 32'(want.is_end), 32'(is_end));
			cmp_field("stopped", 32'(want.stopped), 32'(stopped));
		end
	endtask

	// Everything is sampled at the clock edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale  = TEXT_SCALE_RESET;
			gsize  = GLYPH_SIZE_RESET;
			errors = 0;
			clear_line();
			glyph_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TEXT_SCALE: scale = cfg_wdata;
					REG_GLYPH_SIZE: gsize = cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_glyph();
			if (in_valid && !in_stall)
				decode_byte(text_byte);
			fail_count <= errors;
			pending    <= glyph_q.size();
		end
	end

endmodule

// ===== verif/utf8_decode_text_width_tb.sv =====
// Testbench top for the UTF-8 text width decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module utf8_decode_text_width_tb;
	import u8tw_pkg::*;

	localparam int QUIET_LIMIT = 600;
	localparam int PHASE_BYTES = 200;
	localparam int LONG_CHARS  = 60;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  text_byte;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [7:0]  cfg_wdata;
	logic        out_valid;
	logic        out_stall;
	logic [20:0] codepoint;
	logic        wide;
	logic [10:0] advance;
	logic [15:0] position;
	logic [15:0] char_count;
	logic        is_end;
	logic        stopped;

	int          fail_count;
	int          pending;
	bit          idle_on;
	int          hold_reqs;
	int          holds_done;
	int          bytes_sent;
	int          quiet;
	int          phase_end;
	bit          held;
	logic [7:0]  probe_bytes[$];
	logic [7:0]  scale_set[$];
	logic [6:0]  glyph_set[$];

	utf8_decode_text_width i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.codepoint  (codepoint),
		.wide       (wide),
		.advance    (advance),
		.position   (position),
		.char_count (char_count),
		.is_end     (is_end),
		.stopped    (stopped)
	);

	utf8_decode_text_width_chk i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.codepoint  (codepoint),
		.wide       (wide),
		.advance    (advance),
		.position   (position),
		.char_count (char_count),
		.is_end     (is_end),
		.stopped    (stopped),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one byte and hold it until the decoder takes it, then maybe idle.
	task automatic put_byte(input logic [7:0] b);
		in_valid  <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result item has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// Lead bytes produce nothing, so let the pipeline empty as well.
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Send one string of random characters, mostly well formed, then its NUL.
	task automatic put_string(input int n_chars);
		int         kind;
		int         n_cont;
		int         sent_cont;
		logic [7:0] lead;
		bit         cut;
		cut = 1'b0;
		for (int c = 0; c < n_chars && !cut; c++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				put_byte(8'($urandom_range(1, 127)));
			end else if (kind < 92 || kind >= 95) begin
				// Multi-byte character; the top few use arbitrary continuation bytes.
				n_cont = $urandom_range(1, 3);
				case (n_cont)
					1: lead = LEAD2_CODE | 8'($urandom_range(0, 31));
					2: lead = LEAD3_CODE | 8'($urandom_range(0, 15));
					default: lead = LEAD4_CODE | 8'($urandom_range(0, 7));
				endcase
				put_byte(lead);
				sent_cont = (kind >= 95 && kind < 98) ? $urandom_range(0, n_cont - 1) : n_cont;
				for (int k = 0; k < sent_cont; k++) begin
					if (kind >= 98)
						put_byte(8'($urandom_range(1, 255)));
					else
						put_byte(8'h80 | 8'($urandom_range(0, 63)));
				end
				// A short sequence ends the string in the middle of a character.
				cut = (sent_cont < n_cont);
			end else if (kind < 93) begin
				// Stray byte: often an invalid lead or a lone continuation.
				put_byte(8'($urandom_range(1, 255)));
			end else begin
				// Overlong encoding of zero, which stops the string.
				n_cont = $urandom_range(1, 3);
				case (n_cont)
					1: lead = LEAD2_CODE;
					2: lead = LEAD3_CODE;
					default: lead = LEAD4_CODE;
				endcase
				put_byte(lead);
				for (int k = 0; k < n_cont; k++)
					put_byte(8'h80);
			end
		end
		put_byte(8'h00);
	endtask

	// Output side: random stall bursts, free-running stretches and one long hold.
	initial begin
		out_stall <= 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done != hold_reqs) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 1) == 1) begin
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Watchdog on cycles without any accepted item.
	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Main stimulus.
	initial begin
		in_valid  <= 1'b0;
		text_byte <= 8'h00;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_TEXT_SCALE;
		cfg_wdata <= 8'h00;
		arst_n    <= 1'b0;
		idle_on    = 1'b1;
		hold_reqs  = 0;
		bytes_sent = 0;
		held       = 1'b0;

		// Directed strings with the reset configuration: ASCII extremes, each
		// sequence length, the largest codepoint, then every early stop.
		probe_bytes = '{8'h41, 8'h7F, 8'h01, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00,
			8'h80, 8'h42, 8'h00,
			8'hC0, 8'h80, 8'h00,
			8'hE2, 8'h82, 8'h00,
			8'hFF, 8'h00};
		// Settings per random phase: zero, one, two, large and the extremes.
		scale_set = '{8'd0, 8'd255, 8'd2, 8'd2, 8'd3, 8'd1, 8'd255};
		glyph_set = '{7'd1, 7'd64, 7'd64, 7'd1, 7'd0, 7'd64, 7'd33};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_bytes[i])
			put_byte(probe_bytes[i]);

		for (int p = 0; p < scale_set.size(); p++) begin
			drain();
			if (p == scale_set.size() - 1)
				idle_on = 1'b0;
			write_reg(REG_TEXT_SCALE, scale_set[p]);
			write_reg(REG_GLYPH_SIZE, {1'b0, glyph_set[p]});
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				// Fill the pipeline against a held output once.
				if (p == 2 && !held && bytes_sent > phase_end - 150) begin
					hold_reqs++;
					held = 1'b1;
				end
				// Pause the sender mid-phase until every result has come.
				if (p == 4 && bytes_sent > phase_end - 120 && bytes_sent < phase_end - 100)
					drain();
				if ($urandom_range(0, 7) == 0)
					put_string($urandom_range(30, 60));
				else
					put_string($urandom_range(0, 12));
			end
		end

		// One long ASCII string at the largest scale so that the running width saturates.
		for (int k = 0; k < LONG_CHARS; k++)
			put_byte(8'($urandom_range(1, 127)));
		put_byte(8'h00);

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
